>>> rtl/rle8_pkg.sv
// Shared types and constants for the RLE8 bitmap line decoder.
// No dependencies; used by the decoder.
package rle8_pkg;

    localparam logic [14:0] MAX_WIDTH = 15'd16384;

    localparam int PADDR_W = 3;

    // register index taken from paddr[2]
    typedef enum logic {
        REG_LINE_WIDTH = 1'b0,
        REG_LINE_COUNT = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        PH_TOKEN   = 3'd0,
        PH_FILL    = 3'd1,
        PH_ESCAPE  = 3'd2,
        PH_LITERAL = 3'd3,
        PH_PAD     = 3'd4,
        PH_IDLE    = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        K_PIXEL = 2'd0,
        K_LINE  = 2'd1,
        K_IMAGE = 2'd2,
        K_ERROR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        E_NONE    = 3'd0,
        E_RUN     = 3'd1,
        E_LITERAL = 3'd2,
        E_DELTA   = 3'd3,
        E_SHORT   = 3'd4
    } t_err;

    // escape selector bytes
    localparam logic [7:0] ESC_EOL   = 8'd0;
    localparam logic [7:0] ESC_EOD   = 8'd1;
    localparam logic [7:0] ESC_DELTA = 8'd2;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  pixel_value;
        logic [7:0]  repeat_count;
        logic [13:0] column;
        logic [13:0] row;
        t_err        error_code;
    } t_result;

endpackage

>>> rtl/rle8_byte_if.sv
// Input channel: one compressed stream byte per beat.
// Depends on nothing; valid/ready handshake.
interface rle8_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_image;

    modport source (output valid, data_byte, start_image, input ready);
    modport sink   (input valid, data_byte, start_image, output ready);
endinterface

>>> rtl/rle8_run_if.sv
// Output channel: one decoded result per beat.
// Depends on nothing; valid/ready handshake.
interface rle8_run_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  pixel_value;
    logic [7:0]  repeat_count;
    logic [13:0] column;
    logic [13:0] row;
    logic [2:0]  error_code;

    modport source (output valid, kind, pixel_value, repeat_count, column, row, error_code,
                    input ready);
    modport sink   (input valid, kind, pixel_value, repeat_count, column, row, error_code,
                    output ready);
endinterface

>>> rtl/rle8_bitmap_line_decoder.sv
// RLE8 bitmap line decoder: one compressed byte per cycle in, at most one result out.
// A result is valid the cycle after its byte is accepted (one result register).
// Throughput: one byte per cycle unless output stalls; one logic pass on the stream state.
// A waiting result does not block input unless it is still stalled when the next beat comes.
// Reset (synchronous, active low): line_width = line_count = 1, decoder waits for a token,
// output empty. Depends on rle8_pkg, rle8_byte_if, rle8_run_if.
module rle8_bitmap_line_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rle8_byte_if.sink                     i_byte,
    rle8_run_if.source                    o_run,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rle8_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rle8_pkg::*;

    logic [14:0] r_line_width;
    logic [14:0] r_line_count;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_pending, n_pending;
    logic [7:0]  r_lit_left, n_lit_left;
    logic        r_pad, n_pad;
    logic [14:0] r_pixels_left, n_pixels_left;
    logic [13:0] r_lines_done, n_lines_done;

    logic        r_out_valid;
    t_result     r_out;

    logic        res_valid;
    t_result     res;

    logic        in_fire;
    logic        cfg_wr;
    t_reg        cfg_sel;

    logic [14:0] eff_w;
    logic [14:0] eff_cnt;

    t_phase      cur_phase;
    logic [7:0]  cur_pending;
    logic [7:0]  cur_lit;
    logic        cur_pad;
    logic [14:0] cur_pleft;
    logic [13:0] cur_lines;

    logic [7:0]  b;
    logic        b_gt_left;
    logic        last_line;
    logic        close_bad;
    logic [14:0] fill_sub;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_sel = t_reg'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= 15'd1;
            r_line_count <= 15'd1;
        end else if (cfg_wr) begin
            case (cfg_sel)
                REG_LINE_WIDTH: r_line_width <= pwdata[14:0];
                REG_LINE_COUNT: r_line_count <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            REG_LINE_WIDTH: prdata = {17'd0, r_line_width};
            REG_LINE_COUNT: prdata = {17'd0, r_line_count};
            default:        prdata = 32'd0;
        endcase
    end

    assign eff_w   = (r_line_width > MAX_WIDTH) ? MAX_WIDTH : r_line_width;
    assign eff_cnt = (r_line_count == 15'd0) ? 15'd1 : r_line_count;

    // ---------------- decode ----------------
    assign i_byte.ready = !r_out_valid || o_run.ready;
    assign in_fire      = i_byte.valid && i_byte.ready;
    assign b            = i_byte.data_byte;

    // start_image restarts the stream on this very byte
    always_comb begin
        if (i_byte.start_image) begin
            cur_phase   = PH_TOKEN;
            cur_pending = 8'd0;
            cur_lit     = 8'd0;
            cur_pad     = 1'b0;
            cur_pleft   = eff_w;
            cur_lines   = 14'd0;
        end else begin
            cur_phase   = r_phase;
            cur_pending = r_pending;
            cur_lit     = r_lit_left;
            cur_pad     = r_pad;
            cur_pleft   = r_pixels_left;
            cur_lines   = r_lines_done;
        end
    end

    assign b_gt_left = {7'd0, b} > cur_pleft;
    assign last_line = ({1'b0, cur_lines} + 15'd1) >= eff_cnt;
    // short line, or end of data with lines still to come
    assign close_bad = (cur_pleft != 15'd0) || ((b == ESC_EOD) && !last_line);
    assign fill_sub  = ({7'd0, cur_pending} <= cur_pleft) ? {7'd0, cur_pending} : cur_pleft;

    // next state
    always_comb begin
        n_phase       = cur_phase;
        n_pending     = cur_pending;
        n_lit_left    = cur_lit;
        n_pad         = cur_pad;
        n_pixels_left = cur_pleft;
        n_lines_done  = cur_lines;
        case (cur_phase)
            PH_TOKEN: begin
                if (b == 8'd0) begin
                    n_phase = PH_ESCAPE;
                end else if (b_gt_left) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_pending = b;
                    n_phase   = PH_FILL;
                end
            end
            PH_FILL: begin
                n_pixels_left = cur_pleft - fill_sub;
                n_pending     = 8'd0;
                n_phase       = PH_TOKEN;
            end
            PH_ESCAPE: begin
                if (b == ESC_DELTA) begin
                    n_phase = PH_IDLE;
                end else if (b == ESC_EOL || b == ESC_EOD) begin
                    if (close_bad || last_line) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_lines_done  = cur_lines + 14'd1;
                        n_pixels_left = eff_w;
                        n_phase       = PH_TOKEN;
                    end
                end else if (b_gt_left) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_lit_left = b;
                    n_pad      = b[0];
                    n_phase    = PH_LITERAL;
                end
            end
            PH_LITERAL: begin
                if (cur_pleft != 15'd0) n_pixels_left = cur_pleft - 15'd1;
                n_lit_left = cur_lit - 8'd1;
                if (cur_lit == 8'd1) n_phase = cur_pad ? PH_PAD : PH_TOKEN;
            end
            PH_PAD: begin
                n_pad   = 1'b0;
                n_phase = PH_TOKEN;
            end
            default: ;
        endcase
    end

    // result for this byte
    always_comb begin
        res_valid        = 1'b0;
        res.kind         = K_PIXEL;
        res.pixel_value  = 8'd0;
        res.repeat_count = 8'd0;
        res.column       = 14'(eff_w - cur_pleft);
        res.row          = 14'(eff_cnt - 15'd1 - {1'b0, cur_lines});
        res.error_code   = E_NONE;
        case (cur_phase)
            PH_TOKEN: begin
                if (b != 8'd0 && b_gt_left) begin
                    res_valid      = 1'b1;
                    res.kind       = K_ERROR;
                    res.error_code = E_RUN;
                end
            end
            PH_FILL: begin
                res_valid        = 1'b1;
                res.pixel_value  = b;
                res.repeat_count = cur_pending;
            end
            PH_ESCAPE: begin
                if (b == ESC_DELTA) begin
                    res_valid      = 1'b1;
                    res.kind       = K_ERROR;
                    res.error_code = E_DELTA;
                end else if (b == ESC_EOL || b == ESC_EOD) begin
                    res_valid = 1'b1;
                    if (close_bad) begin
                        res.kind       = K_ERROR;
                        res.error_code = E_SHORT;
                    end else begin
                        res.kind = last_line ? K_IMAGE : K_LINE;
                    end
                end else if (b_gt_left) begin
                    res_valid      = 1'b1;
                    res.kind       = K_ERROR;
                    res.error_code = E_LITERAL;
                end
            end
            PH_LITERAL: begin
                res_valid        = 1'b1;
                res.pixel_value  = b;
                res.repeat_count = 8'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TOKEN;
            r_pending     <= 8'd0;
            r_lit_left    <= 8'd0;
            r_pad         <= 1'b0;
            r_pixels_left <= 15'd1;
            r_lines_done  <= 14'd0;
        end else if (in_fire) begin
            r_phase       <= n_phase;
            r_pending     <= n_pending;
            r_lit_left    <= n_lit_left;
            r_pad         <= n_pad;
            r_pixels_left <= n_pixels_left;
            r_lines_done  <= n_lines_done;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= res_valid;
        end else if (o_run.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && res_valid) begin
            r_out <= res;
        end
    end

    assign o_run.valid        = r_out_valid;
    assign o_run.kind         = r_out.kind;
    assign o_run.pixel_value  = r_out.pixel_value;
    assign o_run.repeat_count = r_out.repeat_count;
    assign o_run.column       = r_out.column;
    assign o_run.row          = r_out.row;
    assign o_run.error_code   = r_out.error_code;

    // ---------------- checks ----------------
    a_pleft_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pixels_left <= MAX_WIDTH)
        else $error("pixels_left beyond maximum width");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind == K_ERROR) |-> (r_out.error_code != E_NONE))
        else $error("error beat without error code");

    a_pixel_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.kind == K_PIXEL) |-> (r_out.repeat_count != 8'd0))
        else $error("pixel beat with zero repeat");

    a_term_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && res_valid && (res.kind == K_ERROR || res.kind == K_IMAGE)
        |=> (r_phase == PH_IDLE))
        else $error("decoder not idle after error or image end");

endmodule
